[rtl/core/asrb_pkg.sv]
// Shared types and constants for the accelerometer sample ring buffer
`timescale 1ns / 1ps

package asrb_pkg;

  // request codes carried in the kind field
  localparam logic [1:0] KindPush  = 2'd0;
  localparam logic [1:0] KindPop   = 2'd1;
  localparam logic [1:0] KindClear = 2'd2;

  // zero-g offset of the raw conversions
  localparam logic [11:0] ZeroG = 12'd2048;

  // most samples one pop may return
  localparam logic [6:0] MaxPop = 7'd64;

  // ceiling of the stored_left field
  localparam int LeftMax = 127;

  // response status codes
  localparam logic StatusSample = 1'b0;
  localparam logic StatusEmpty  = 1'b1;

  // one stored three-axis sample
  typedef struct packed {
    logic signed [11:0] x;
    logic signed [11:0] y;
    logic signed [11:0] z;
  } sample_t;

  // request word
  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] x_raw;
    logic [11:0] y_raw;
    logic [11:0] z_raw;
    logic        sample_ok;
    logic [6:0]  max_pop;
  } in_word_t;

  // response word
  typedef struct packed {
    logic               status;
    logic signed [11:0] x_accel;
    logic signed [11:0] y_accel;
    logic signed [11:0] z_accel;
    logic               is_last;
    logic               overflow_seen;
    logic [6:0]         stored_left;
  } out_word_t;

endpackage

[rtl/core/asrb_store.sv]
// Sample memory: one write port, one read port with registered read data
`timescale 1ns / 1ps

module asrb_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  asrb_pkg::sample_t wr_data_i,
  input  logic              rd_en_i,
  input  logic [AW-1:0]     rd_addr_i,
  output asrb_pkg::sample_t rd_data_o
);

  asrb_pkg::sample_t mem_q [DEPTH];
  asrb_pkg::sample_t rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/core/accel_sample_ring_buffer_top.sv]
// Top level of the accelerometer sample ring buffer
`timescale 1ns / 1ps

// Ring of DEPTH three-axis samples kept in a single-port-write, single-port-read
// memory. A push (raw minus 2048 per axis) or a clear gives no response; a
// failed push is dropped. When the ring is full a push replaces the oldest
// sample and sets the sticky overflow flag, which only reset clears. A pop on
// an empty ring gives one empty response word via StEmpty. A pop of n samples
// (n = min(stored, max_pop clamped to 1..64)) runs the sequencer through StRead
// to read the memory and StLoad to load the output register, once per sample,
// StLoad waiting out any output stall; no request is taken until the last word
// of the pop is loaded. Pushes and clears are taken while a response still
// waits in the output register. No clearing pass after reset.

module accel_sample_ring_buffer_top #(
  parameter int DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  asrb_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output asrb_pkg::out_word_t out_word_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StLoad,
    StEmpty
  } state_e;

  state_e              state_q;
  logic [AW-1:0]       rp_q;
  logic [AW-1:0]       wp_q;
  logic [CW-1:0]       cnt_q;
  logic                ovf_q;
  logic [6:0]          left_q;
  logic                out_valid_q;
  asrb_pkg::out_word_t out_word_q;

  logic              accept;
  logic              out_free;
  logic              out_load;
  logic              wr_en;
  logic              rd_en;
  logic [6:0]        req;
  logic [6:0]        pop_n;
  logic [CW-1:0]     cnt_dec;
  asrb_pkg::sample_t wr_data;
  asrb_pkg::sample_t rd_data;

  // ring pointer advance
  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
    next_slot = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // stored count as reported, saturated
  function automatic logic [6:0] left_field(input logic [CW-1:0] c);
    left_field = (32'(c) > asrb_pkg::LeftMax) ? 7'(asrb_pkg::LeftMax) : 7'(c);
  endfunction

  // handshake
  assign accept     = in_valid_i && (state_q == StIdle);
  assign in_stall_o = (state_q != StIdle);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = out_free && ((state_q == StLoad) || (state_q == StEmpty));

  // push data with zero-g offset removed
  assign wr_data.x = 12'(in_word_i.x_raw - asrb_pkg::ZeroG);
  assign wr_data.y = 12'(in_word_i.y_raw - asrb_pkg::ZeroG);
  assign wr_data.z = 12'(in_word_i.z_raw - asrb_pkg::ZeroG);
  assign wr_en     = accept && (in_word_i.kind == asrb_pkg::KindPush) && in_word_i.sample_ok;
  assign rd_en     = (state_q == StRead);

  // pop length: request clamped to 1..64, then to the stored count
  always_comb begin
    priority if (in_word_i.max_pop == 7'd0) begin
      req = 7'd1;
    end else if (in_word_i.max_pop > asrb_pkg::MaxPop) begin
      req = asrb_pkg::MaxPop;
    end else begin
      req = in_word_i.max_pop;
    end
    pop_n = (32'(cnt_q) < 32'(req)) ? 7'(cnt_q) : req;
  end

  assign cnt_dec = cnt_q - 1'b1;

  asrb_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wp_q),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rp_q),
    .rd_data_o (rd_data)
  );

  // sequencer, ring state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      rp_q        <= '0;
      wp_q        <= '0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
    end else begin
      // output register: loaded by the sequencer, emptied when taken
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (accept) begin
            unique case (in_word_i.kind)
              asrb_pkg::KindPush: begin
                if (in_word_i.sample_ok) begin
                  wp_q <= next_slot(wp_q);
                  if (cnt_q == CW'(DEPTH)) begin
                    ovf_q <= 1'b1;
                    rp_q  <= next_slot(rp_q);
                  end else begin
                    cnt_q <= cnt_q + 1'b1;
                  end
                end
              end
              asrb_pkg::KindPop: begin
                if (cnt_q == '0) begin
                  state_q <= StEmpty;
                end else begin
                  left_q  <= pop_n;
                  state_q <= StRead;
                end
              end
              asrb_pkg::KindClear: begin
                cnt_q <= '0;
                rp_q  <= '0;
                wp_q  <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        StRead: begin
          state_q <= StLoad;
        end
        StLoad: begin
          if (out_free) begin
            out_word_q.status          <= asrb_pkg::StatusSample;
            out_word_q.x_accel         <= rd_data.x;
            out_word_q.y_accel         <= rd_data.y;
            out_word_q.z_accel         <= rd_data.z;
            out_word_q.is_last         <= (left_q == 7'd1);
            out_word_q.overflow_seen   <= ovf_q;
            out_word_q.stored_left     <= left_field(cnt_dec);
            rp_q                       <= next_slot(rp_q);
            cnt_q                      <= cnt_dec;
            left_q                     <= left_q - 1'b1;
            state_q                    <= (left_q == 7'd1) ? StIdle : StRead;
          end
        end
        StEmpty: begin
          if (out_free) begin
            out_word_q.status          <= asrb_pkg::StatusEmpty;
            out_word_q.x_accel         <= '0;
            out_word_q.y_accel         <= '0;
            out_word_q.z_accel         <= '0;
            out_word_q.is_last         <= 1'b1;
            out_word_q.overflow_seen   <= ovf_q;
            out_word_q.stored_left     <= left_field(cnt_q);
            state_q                    <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the accelerometer sample ring buffer
`timescale 1ns / 1ps

module tb_top;
  import asrb_pkg::*;

  localparam int Depth      = 64;
  localparam int QuietLimit = 4000;
  localparam int TailCycles = 20;
  localparam int InBits     = $bits(in_word_t);

  // the one kind value the block has no use for
  localparam logic [1:0] KindUnused = 2'd3;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_word_o;

  // shadow copy of the ring
  sample_t     ring_mem [Depth];
  int unsigned rd_idx   = 0;
  int unsigned wr_idx   = 0;
  int unsigned fill     = 0;
  logic        ovf_flag = 1'b0;

  out_word_t pop_results_due [$];
  out_word_t due_word;
  int        err_count    = 0;
  int        quiet_cycles = 0;
  int        stall_run    = 0;
  bit        idling_on    = 1'b1;

  accel_sample_ring_buffer_top #(
    .DEPTH(Depth)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int unsigned next_idx(input int unsigned p);
    return (p == Depth - 1) ? 0 : p + 1;
  endfunction

  // advance the shadow ring by one accepted word and queue the pop results
  function automatic void apply_request(input in_word_t w);
    int unsigned req;
    int unsigned n;
    sample_t     s;
    out_word_t   o;
    case (w.kind)
      KindPush: begin
        if (w.sample_ok) begin
          s.x = w.x_raw - ZeroG;
          s.y = w.y_raw - ZeroG;
          s.z = w.z_raw - ZeroG;
          ring_mem[wr_idx] = s;
          // full ring drops the oldest sample
          if (fill == Depth) begin
            ovf_flag = 1'b1;
            rd_idx   = next_idx(rd_idx);
          end else begin
            fill++;
          end
          wr_idx = next_idx(wr_idx);
        end
      end
      KindPop: begin
        req = w.max_pop;
        if (req == 0) req = 1;
        if (req > MaxPop) req = MaxPop;
        if (fill == 0) begin
          o               = '0;
          o.status        = StatusEmpty;
          o.is_last       = 1'b1;
          o.overflow_seen = ovf_flag;
          pop_results_due.push_back(o);
        end else begin
          n = (fill < req) ? fill : req;
          for (int unsigned k = 0; k < n; k++) begin
            s      = ring_mem[rd_idx];
            rd_idx = next_idx(rd_idx);
            fill--;
            o.status        = StatusSample;
            o.x_accel       = s.x;
            o.y_accel       = s.y;
            o.z_accel       = s.z;
            o.is_last       = (k == n - 1);
            o.overflow_seen = ovf_flag;
            o.stored_left   = (fill > LeftMax) ? 7'(LeftMax) : 7'(fill);
            pop_results_due.push_back(o);
          end
        end
      end
      KindClear: begin
        fill   = 0;
        rd_idx = 0;
        wr_idx = 0;
      end
      default: begin
      end
    endcase
  endfunction

  task automatic report_field(input string name, input logic signed [12:0] due,
                              input logic signed [12:0] got);
    if (due !== got) begin
      err_count++;
      $display("%0t: %s expected %0d actual %0d", $time, name, due, got);
    end
  endtask

  // compare returned words, then track accepted requests
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pop_results_due.size() == 0) begin
        err_count++;
        $display("%0t: word with none expected, expected none actual %p", $time,
                 out_word_o);
      end else begin
        due_word = pop_results_due.pop_front();
        report_field("status", 13'(due_word.status), 13'(out_word_o.status));
        report_field("x_accel", 13'(due_word.x_accel), 13'(out_word_o.x_accel));
        report_field("y_accel", 13'(due_word.y_accel), 13'(out_word_o.y_accel));
        report_field("z_accel", 13'(due_word.z_accel), 13'(out_word_o.z_accel));
        report_field("is_last", 13'(due_word.is_last), 13'(out_word_o.is_last));
        report_field("overflow_seen", 13'(due_word.overflow_seen),
                     13'(out_word_o.overflow_seen));
        report_field("stored_left", 13'(due_word.stored_left),
                     13'(out_word_o.stored_left));
      end
    end
    if (rst_ni && in_valid_i && !in_stall_o) begin
      apply_request(in_word_i);
    end
  end

  // receiver stalls in random bursts, none while idling is off
  always @(posedge clk_i) begin
    if (!idling_on) begin
      stall_run = 0;
      out_stall_i <= 1'b0;
    end else if (stall_run > 0) begin
      stall_run--;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_run = $urandom_range(0, 3);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // watchdog on cycles with no word moving either way
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [11:0] raw_value();
    case ($urandom_range(0, 9))
      0: return 12'd0;
      1: return 12'hFFF;
      2: return ZeroG;
      3: return ZeroG - 12'd1;
      default: return 12'($urandom);
    endcase
  endfunction

  function automatic in_word_t sample_word(input logic [11:0] x, input logic [11:0] y,
                                           input logic [11:0] z, input logic ok);
    in_word_t w;
    w.kind      = KindPush;
    w.x_raw     = x;
    w.y_raw     = y;
    w.z_raw     = z;
    w.sample_ok = ok;
    w.max_pop   = 7'($urandom);
    return w;
  endfunction

  // word of the given kind with random filler in the unused fields
  function automatic in_word_t noise_word(input logic [1:0] kind);
    in_word_t w;
    w      = in_word_t'(InBits'({$urandom, $urandom}));
    w.kind = kind;
    return w;
  endfunction

  function automatic in_word_t pop_word(input logic [6:0] req);
    in_word_t w;
    w         = noise_word(KindPop);
    w.max_pop = req;
    return w;
  endfunction

  function automatic logic [6:0] pop_size();
    if ($urandom_range(0, 7) == 0) return 7'($urandom_range(0, 127));
    return 7'($urandom_range(1, 6));
  endfunction

  function automatic in_word_t random_sample();
    return sample_word(raw_value(), raw_value(), raw_value(), 1'b1);
  endfunction

  // offer one word and hold it until the block takes it
  task automatic send_word(input in_word_t w);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
  endtask

  // stop sending and wait for every queued sample to come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pop_results_due.size() != 0) @(posedge clk_i);
  endtask

  // pops and odd words on a ring that was never written
  task automatic test_empty_store();
    send_word(pop_word(7'd0));
    send_word(noise_word(KindUnused));
    send_word(noise_word(KindClear));
    send_word(pop_word(7'd127));
    drain_results();
  endtask

  // raw extremes, a failed transfer and the request size clamps
  task automatic test_push_extremes();
    send_word(sample_word(12'd0, 12'hFFF, ZeroG, 1'b1));
    send_word(sample_word(12'hFFF, ZeroG - 12'd1, 12'd0, 1'b1));
    send_word(sample_word(ZeroG, 12'd0, 12'hFFF, 1'b1));
    send_word(sample_word(12'hAAA, 12'h555, 12'h123, 1'b0));
    send_word(sample_word(ZeroG - 12'd1, ZeroG + 12'd1, 12'd1, 1'b1));
    send_word(pop_word(7'd2));
    send_word(pop_word(7'd0));
    send_word(pop_word(MaxPop));
    send_word(pop_word(7'd1));
    drain_results();
  endtask

  // wrap the ring past full, then read it back and clear it
  task automatic test_ring_overflow();
    repeat (Depth + $urandom_range(3, 10)) send_word(random_sample());
    send_word(pop_word(7'd100));
    send_word(pop_word(7'd1));
    repeat (Depth) send_word(random_sample());
    send_word(pop_word(7'd65));
    repeat ($urandom_range(3, 8)) send_word(random_sample());
    send_word(noise_word(KindClear));
    send_word(pop_word(pop_size()));
    repeat ($urandom_range(2, 5)) send_word(random_sample());
    send_word(pop_word(MaxPop));
    drain_results();
  endtask

  // mixed traffic, mostly valid samples and pops of random size
  task automatic test_random_traffic(input int count, input bit with_gaps);
    int pick;
    for (int i = 0; i < count; i++) begin
      if (with_gaps && i % 40 == 0) idling_on = ($urandom_range(0, 3) != 0);
      if (i == count / 2) drain_results();
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        send_word(sample_word(raw_value(), raw_value(), raw_value(),
                              $urandom_range(0, 9) != 0));
      end else if (pick < 88) begin
        send_word(pop_word(pop_size()));
      end else if (pick < 94) begin
        send_word(noise_word(KindClear));
      end else begin
        send_word(noise_word(KindUnused));
      end
    end
  endtask

  // closing stretch at full rate on both sides
  task automatic test_back_to_back();
    idling_on = 1'b0;
    test_random_traffic(80, 1'b0);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_store();
    test_push_extremes();
    test_ring_overflow();
    test_random_traffic(140, 1'b1);
    test_back_to_back();
    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    if (pop_results_due.size() != 0) begin
      err_count++;
      $display("%0t: words outstanding expected 0 actual %0d", $time,
               pop_results_due.size());
    end
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/asrb_pkg.sv
rtl/core/asrb_store.sv
rtl/core/accel_sample_ring_buffer_top.sv
tb/tb_top.sv
